// ----- rtl/core/dart_pkg.sv -----
// Package for the divider and reloading timer: request and register codes,
// controller state type and the command/status structs between the modules.
// No dependencies.
`default_nettype none

package dart_pkg;

	// Request kinds carried in tuser
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_DIV  = 2'd0;
	localparam logic [1:0] REG_CNT  = 2'd1;
	localparam logic [1:0] REG_MOD  = 2'd2;
	localparam logic [1:0] REG_CTRL = 2'd3;

	// Counter period selects
	localparam logic [1:0] RATE_256 = 2'd0;
	localparam logic [1:0] RATE_4   = 2'd1;
	localparam logic [1:0] RATE_16  = 2'd2;
	localparam logic [1:0] RATE_64  = 2'd3;

	localparam logic [7:0] DIV_RESET = 8'h18;

	// Increments per tick: at most (255 + 255) / 4
	localparam int STEP_W = 7;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic steps_left;
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/core/divider_and_reloading_timer.sv -----
// Four-register timer: free-running divider and reloading counter with
// interrupt request. Top level; uses dart_pkg, dart_ctrl, dart_datapath.
//
// Each item is a tick, a register write or a register read, and gives one
// result item. An item is loaded when accepted, then passes ST_STEP and ST_DONE
// into the output register; a tick stays in ST_STEP for n counter increments, where n
// is at most 127 with the period of 4, since the counter advances by one increment
// a cycle so that each wrap reloads from the modulo register. A finished result
// waits in the output register while the next item is taken. The divider resets
// to 0x18, all other registers to zero.
`default_nettype none

module divider_and_reloading_timer
	import dart_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// [1:0] reg_index, [9:2] write_data, [17:10] cycle_count, rest zero
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// [1:0] req_type
	input  wire logic [1:0]           s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// [7:0] read_data, [8] irq_request, rest zero
	output logic [M_TDATA_W-1:0]      m_tdata
);

	cmd_t    cmd;
	status_t status;

	dart_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	dart_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_type    (s_tuser),
		.reg_index   (s_tdata[1:0]),
		.write_data  (s_tdata[9:2]),
		.cycle_count (s_tdata[17:10]),
		.cmd         (cmd),
		.status      (status),
		.out_data    (m_tdata)
	);

endmodule

`default_nettype wire

// ----- rtl/core/dart_ctrl.sv -----
// Controller state machine of the timer: takes items, sequences counter
// increments and hands results to the output register. Uses dart_pkg.
`default_nettype none

module dart_ctrl
	import dart_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  wire logic    m_tready,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_STEP;
				end
			end
			ST_STEP: begin
				if (status.steps_left) begin
					cmd.step = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the output valid until the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/dart_datapath.sv -----
// Datapath of the timer: divider, counter, modulo and control registers,
// the increment step counter and the output register. Uses dart_pkg.
`default_nettype none

module dart_datapath
	import dart_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [1:0]             req_type,
	input  wire logic [1:0]             reg_index,
	input  wire logic [7:0]             write_data,
	input  wire logic [7:0]             cycle_count,
	input  wire cmd_t                   cmd,
	output status_t                     status,
	output logic [M_TDATA_W-1:0]        out_data
);

	logic [7:0]        div_sub_q;
	logic [7:0]        cnt_sub_q;
	logic [7:0]        div_q;
	logic [7:0]        cnt_q;
	logic [7:0]        mod_q;
	logic              en_q;
	logic [1:0]        rate_q;
	logic [STEP_W-1:0] steps_q;
	logic              irq_q;
	logic [7:0]        rd_q;
	logic [M_TDATA_W-1:0] out_q;

	logic [8:0]        div_acc;
	logic [8:0]        cnt_acc;
	logic [STEP_W-1:0] steps_d;
	logic [7:0]        sub_d;
	logic [7:0]        rd_d;

	// Sub-count sums of the tick
	assign div_acc = {1'b0, div_sub_q} + {1'b0, cycle_count};
	assign cnt_acc = {1'b0, cnt_sub_q} + {1'b0, cycle_count};

	// Split the counter sum into whole periods and remainder
	always_comb begin
		case (rate_q)
			RATE_256: begin
				steps_d = {{(STEP_W-1){1'b0}}, cnt_acc[8]};
				sub_d   = cnt_acc[7:0];
			end
			RATE_4: begin
				steps_d = cnt_acc[8:2];
				sub_d   = {6'd0, cnt_acc[1:0]};
			end
			RATE_16: begin
				steps_d = {2'd0, cnt_acc[8:4]};
				sub_d   = {4'd0, cnt_acc[3:0]};
			end
			RATE_64: begin
				steps_d = {4'd0, cnt_acc[8:6]};
				sub_d   = {2'd0, cnt_acc[5:0]};
			end
			default: begin
				steps_d = '0;
				sub_d   = cnt_acc[7:0];
			end
		endcase
	end

	// Register read mux
	always_comb begin
		case (reg_index)
			REG_DIV:  rd_d = div_q;
			REG_CNT:  rd_d = cnt_q;
			REG_MOD:  rd_d = mod_q;
			REG_CTRL: rd_d = {5'd0, en_q, rate_q};
			default:  rd_d = 8'd0;
		endcase
	end

	// Timer state: load on an item, advance the counter one increment a step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_sub_q <= 8'd0;
			cnt_sub_q <= 8'd0;
			div_q     <= DIV_RESET;
			cnt_q     <= 8'd0;
			mod_q     <= 8'd0;
			en_q      <= 1'b0;
			rate_q    <= RATE_256;
			steps_q   <= '0;
			irq_q     <= 1'b0;
			rd_q      <= 8'd0;
		end else if (cmd.load) begin
			irq_q <= 1'b0;
			case (req_type)
				REQ_TICK: begin
					rd_q      <= 8'd0;
					div_sub_q <= div_acc[7:0];
					div_q     <= div_q + {7'd0, div_acc[8]};
					if (en_q) begin
						steps_q   <= steps_d;
						cnt_sub_q <= sub_d;
					end else begin
						steps_q <= '0;
					end
				end
				REQ_WRITE: begin
					rd_q    <= 8'd0;
					steps_q <= '0;
					case (reg_index)
						REG_DIV:  div_q <= 8'd0;
						REG_CNT:  cnt_q <= write_data;
						REG_MOD:  mod_q <= write_data;
						REG_CTRL: begin
							rate_q <= write_data[1:0];
							en_q   <= write_data[2];
						end
						default: begin
							div_q <= div_q;
						end
					endcase
				end
				REQ_READ: begin
					rd_q    <= rd_d;
					steps_q <= '0;
				end
				default: begin
					rd_q    <= 8'd0;
					steps_q <= '0;
				end
			endcase
		end else if (cmd.step) begin
			steps_q <= steps_q - {{(STEP_W-1){1'b0}}, 1'b1};
			if (cnt_q == 8'hFF) begin
				cnt_q <= mod_q;
				irq_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 8'd1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= {{(M_TDATA_W-9){1'b0}}, irq_q, rd_q};
		end
	end

	assign status.steps_left = (steps_q != '0);
	assign out_data          = out_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the divider and reloading timer: drives tick, write
// and read items on the input stream and checks every reply against a timer
// model kept in a small scoreboard class. Depends on dart_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_top;
	import dart_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int unsigned DIV_PERIOD = 256;
	localparam int CLK_LIMIT_NS = 2_000_000;
	localparam int TAIL_CYCLES = 140;

	typedef struct packed {
		logic       irq;
		logic [7:0] rd;
	} timer_reply_t;

	// Timer model plus the queue of replies it predicts
	class timer_scoreboard;
		bit [7:0] div_frac;
		bit [7:0] cnt_frac;
		bit [7:0] div_count;
		bit [7:0] cnt_count;
		bit [7:0] reload_value;
		bit       cnt_enabled;
		bit [1:0] rate_sel;
		timer_reply_t pending_replies[$];
		int mismatches;
		int strays;
		int replies_seen;
		int irqs_seen;

		function new();
			div_count = DIV_RESET;
		endfunction

		function int unsigned period_of(bit [1:0] sel);
			case (sel)
				RATE_4:  return 4;
				RATE_16: return 16;
				RATE_64: return 64;
				default: return 256;
			endcase
		endfunction

		// Advance the model by one accepted item and queue its reply
		function void note_request(bit [1:0] req, bit [1:0] idx, bit [7:0] wdata,
				bit [7:0] cycles);
			timer_reply_t reply;
			int unsigned acc;
			int unsigned period;
			reply = '0;
			case (req)
				REQ_TICK: begin
					acc = div_frac + cycles;
					while (acc >= DIV_PERIOD) begin
						acc -= DIV_PERIOD;
						div_count++;
					end
					div_frac = acc[7:0];
					// counter sub-count is frozen while disabled
					if (cnt_enabled) begin
						period = period_of(rate_sel);
						acc = cnt_frac + cycles;
						while (acc >= period) begin
							acc -= period;
							cnt_count++;
							if (cnt_count == 8'd0) begin
								cnt_count = reload_value;
								reply.irq = 1'b1;
							end
						end
						cnt_frac = acc[7:0];
					end
				end
				REQ_WRITE: begin
					case (idx)
						REG_DIV: div_count = 8'd0;
						REG_CNT: cnt_count = wdata;
						REG_MOD: reload_value = wdata;
						default: begin
							rate_sel = wdata[1:0];
							cnt_enabled = wdata[2];
						end
					endcase
				end
				REQ_READ: begin
					case (idx)
						REG_DIV: reply.rd = div_count;
						REG_CNT: reply.rd = cnt_count;
						REG_MOD: reply.rd = reload_value;
						default: reply.rd = {5'd0, cnt_enabled, rate_sel};
					endcase
				end
				default: ;
			endcase
			pending_replies.push_back(reply);
		endfunction

		function void report(string field, logic [7:0] want, logic [7:0] got);
			mismatches++;
			if (mismatches + strays <= 10)
				$display("%0t: %s mismatch on reply %0d: expected %0h, got %0h",
					$time, field, replies_seen, want, got);
		endfunction

		// Compare one reply from the block with the oldest prediction
		function void check_reply(logic [M_TDATA_W-1:0] data);
			timer_reply_t want;
			replies_seen++;
			if (data[8] === 1'b1)
				irqs_seen++;
			if (pending_replies.size() == 0) begin
				strays++;
				if (mismatches + strays <= 10)
					$display("%0t: reply %0h arrived with none outstanding", $time, data);
				return;
			end
			want = pending_replies.pop_front();
			if (data[7:0] !== want.rd)
				report("read_data", want.rd, data[7:0]);
			if (data[8] !== want.irq)
				report("irq_request", {7'd0, want.irq}, {7'd0, data[8]});
		endfunction

		function int failures();
			return mismatches + strays + pending_replies.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// [1:0] reg_index, [9:2] write_data, [17:10] cycle_count, rest zero
	logic [S_TDATA_W-1:0] s_tdata;
	// [1:0] req_type
	logic [1:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	// [7:0] read_data, [8] irq_request, rest zero
	logic [M_TDATA_W-1:0] m_tdata;

	timer_scoreboard board = new();
	bit src_idle;
	bit sink_idle;
	bit sink_hold;
	int hold_request = 0;
	int kind_count[4];

	divider_and_reloading_timer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int draw_gap(bit enabled);
		return enabled ? int'($urandom_range(0, 9)) : 0;
	endfunction

	// Offer one item from a falling edge and hold it until accepted
	task automatic send_item(input logic [1:0] req, input logic [1:0] idx,
			input logic [7:0] wdata, input logic [7:0] cycles);
		int gap;
		gap = draw_gap(src_idle);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {6'd0, cycles, wdata, idx};
		do @(posedge clk); while (s_tready !== 1'b1);
		board.note_request(req, idx, wdata, cycles);
		kind_count[req]++;
		@(negedge clk);
	endtask

	// Mostly ticks and reads, with writes that keep the counter busy
	task automatic send_random();
		int pick;
		logic [1:0] req;
		logic [1:0] idx;
		logic [7:0] wdata;
		logic [7:0] cycles;
		pick = $urandom_range(0, 99);
		if (pick < 48)
			req = REQ_TICK;
		else if (pick < 70)
			req = REQ_WRITE;
		else if (pick < 95)
			req = REQ_READ;
		else
			req = REQ_UNUSED;
		idx = 2'($urandom_range(0, 3));
		wdata = 8'($urandom_range(0, 255));
		if (req == REQ_WRITE && idx == REG_CTRL)
			wdata[2] = ($urandom_range(0, 9) < 7);
		pick = $urandom_range(0, 9);
		if (pick < 2)
			cycles = 8'($urandom_range(0, 8));
		else if (pick == 2)
			cycles = 8'hff;
		else
			cycles = 8'($urandom_range(0, 255));
		send_item(req, idx, wdata, cycles);
	endtask

	// Drop valid and wait until every predicted reply has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (board.pending_replies.size() != 0);
	endtask

	// Receiver: random ready gaps, plus the long hold when one is requested
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap(sink_idle);
			if (gap > 0 || sink_hold) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
				while (sink_hold) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			board.check_reply(m_tdata);
			@(negedge clk);
		end
	end

	// Count out a long receiver hold-off
	initial begin
		sink_hold = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				sink_hold = 1'b1;
				repeat (hold_request) @(posedge clk);
				sink_hold = 1'b0;
				hold_request = 0;
			end
		end
	end

	initial begin
		#(CLK_LIMIT_NS);
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = REQ_TICK;
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values, then a tick with a cycle_count of zero and the counter off
		send_item(REQ_READ, REG_DIV, 8'h00, 8'h00);
		send_item(REQ_READ, REG_CNT, 8'hff, 8'hff);
		send_item(REQ_READ, REG_MOD, 8'h00, 8'h00);
		send_item(REQ_READ, REG_CTRL, 8'h00, 8'h00);
		send_item(REQ_TICK, REG_DIV, 8'h00, 8'h00);
		// control upper bits ignored; wrap twice with the period of 64
		send_item(REQ_WRITE, REG_CTRL, 8'hff, 8'h00);
		send_item(REQ_READ, REG_CTRL, 8'h00, 8'h00);
		send_item(REQ_WRITE, REG_MOD, 8'hff, 8'h00);
		send_item(REQ_WRITE, REG_CNT, 8'hfe, 8'h00);
		send_item(REQ_TICK, REG_DIV, 8'h00, 8'hff);
		send_item(REQ_READ, REG_CNT, 8'h00, 8'h00);
		// build a large sub-count at 256, then spend it with the period of 4
		send_item(REQ_WRITE, REG_CTRL, 8'h04, 8'h00);
		send_item(REQ_TICK, REG_DIV, 8'h00, 8'hfa);
		send_item(REQ_WRITE, REG_CTRL, 8'h05, 8'h00);
		send_item(REQ_TICK, REG_DIV, 8'h00, 8'h00);
		send_item(REQ_READ, REG_CNT, 8'h00, 8'h00);
		// disabled counter keeps its value
		send_item(REQ_WRITE, REG_CTRL, 8'hfb, 8'h00);
		send_item(REQ_TICK, REG_DIV, 8'h00, 8'hc8);
		send_item(REQ_READ, REG_CNT, 8'h00, 8'h00);
		// divider write clears the count only
		send_item(REQ_WRITE, REG_DIV, 8'ha5, 8'h00);
		send_item(REQ_READ, REG_DIV, 8'h00, 8'h00);
		send_item(REQ_TICK, REG_DIV, 8'h00, 8'hff);
		send_item(REQ_READ, REG_DIV, 8'h00, 8'h00);
		// unused request kind with every field bit set
		send_item(REQ_UNUSED, 2'b11, 8'hff, 8'hff);
		send_item(REQ_WRITE, REG_MOD, 8'h00, 8'h00);
		send_item(REQ_WRITE, REG_CNT, 8'h00, 8'h00);
		wait_drained();

		// random phases with changing idle patterns
		for (int phase = 0; phase < 11; phase++) begin
			if (phase == 0) begin
				src_idle  = 1'b0;
				sink_idle = 1'b0;
			end else if (phase == 1) begin
				src_idle  = 1'b1;
				sink_idle = 1'b1;
			end else begin
				src_idle  = ($urandom_range(0, 3) != 0);
				sink_idle = ($urandom_range(0, 3) != 0);
			end
			repeat (100) send_random();
			if (phase == 5) begin
				// stall the receiver while the sender keeps offering
				wait_drained();
				hold_request = 300;
				src_idle = 1'b0;
				repeat (40) send_random();
			end
			if ($urandom_range(0, 1) == 1)
				wait_drained();
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d ticks, %0d writes, %0d reads, %0d unused requests",
			kind_count[REQ_TICK], kind_count[REQ_WRITE], kind_count[REQ_READ],
			kind_count[REQ_UNUSED]);
		$display("%0d replies checked, %0d with overflow interrupt, %0d errors",
			board.replies_seen, board.irqs_seen, board.failures());
		if (board.failures() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
